FILE: sv/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// csvfs_pkg
// Types and constants that the field splitter's modules share.
// ----------------------------------------------------------------------------
package csvfs_pkg;

    localparam int unsigned CharW = 16;
    localparam int unsigned LenW  = 3;

    localparam logic [CharW-1:0] ChQuote = 16'd34;
    localparam logic [CharW-1:0] ChCr    = 16'd13;
    localparam logic [CharW-1:0] ChLf    = 16'd10;

    localparam logic [CharW-1:0] SeparatorReset = 16'd44;
    localparam logic [CharW-1:0] CapacityReset  = 16'd256;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_SEPARATOR = 1'b0,
        CFG_CAPACITY  = 1'b1
    } t_cfg_idx;

    // Parser mode within the current field.
    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_QUOTED = 2'd2,
        MODE_CLOSED = 2'd3
    } t_mode;

    // What ended a field.
    typedef enum logic [2:0] {
        TERM_SEP   = 3'd0,
        TERM_CR    = 3'd1,
        TERM_LF    = 3'd2,
        TERM_END   = 3'd3,
        TERM_OTHER = 3'd4
    } t_term;

    // Kind of result.
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [CharW-1:0] in_char;
        logic [LenW-1:0]  in_len;
        logic             in_end;
    } t_item;

    typedef struct packed {
        t_mode            mode;
        logic [CharW-1:0] space_left;
        logic             swallow_lf;
        logic             dropped_any;
    } t_state;

    typedef struct packed {
        t_kind            out_kind;
        logic [CharW-1:0] out_char;
        t_term            terminator;
        logic             end_of_record;
        logic             truncated;
    } t_result;

endpackage

FILE: sv/csvfs_in_if.sv
// ----------------------------------------------------------------------------
// csvfs_in_if
// Input channel: one decoded character per transaction.
// ----------------------------------------------------------------------------
interface csvfs_in_if;

    logic        valid;
    logic        ready;
    logic [15:0] in_char;
    logic [2:0]  in_len;
    logic        in_end;

    modport source (output valid, output in_char, output in_len, output in_end,
                    input ready);
    modport sink   (input valid, input in_char, input in_len, input in_end,
                    output ready);

endinterface

FILE: sv/csvfs_out_if.sv
// ----------------------------------------------------------------------------
// csvfs_out_if
// Output channel: one parser result per transaction.
// ----------------------------------------------------------------------------
interface csvfs_out_if;

    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [15:0] out_char;
    logic [2:0]  terminator;
    logic        end_of_record;
    logic        truncated;

    modport source (output valid, output out_kind, output out_char,
                    output terminator, output end_of_record, output truncated,
                    input ready);
    modport sink   (input valid, input out_kind, input out_char,
                    input terminator, input end_of_record, input truncated,
                    output ready);

endinterface

FILE: sv/csvfs_step.sv
// ----------------------------------------------------------------------------
// csvfs_step
// Combinational parser step: next state and result for one character.
// ----------------------------------------------------------------------------
module csvfs_step (
    input  csvfs_pkg::t_item   i_item,
    input  csvfs_pkg::t_state  i_state,
    input  logic [15:0]        i_separator,
    input  logic [15:0]        i_capacity,
    output csvfs_pkg::t_state  o_state,
    output csvfs_pkg::t_result o_result
);
    import csvfs_pkg::*;

    logic [CharW-1:0] space_cur;
    logic             dropped_cur;
    logic             swallow;
    logic             do_end;
    logic             do_put;
    t_term            term;
    t_term            cls;
    t_mode            mode_nx;
    logic [CharW-1:0] len_ext;
    logic             fits;

    // Classification of the character against the field terminators.
    always_comb begin
        if (i_item.in_char == i_separator) begin
            cls = TERM_SEP;
        end else if (i_item.in_char == ChCr) begin
            cls = TERM_CR;
        end else if (i_item.in_char == ChLf) begin
            cls = TERM_LF;
        end else begin
            cls = TERM_OTHER;
        end
    end

    assign len_ext = {{(CharW-LenW){1'b0}}, i_item.in_len};

    // Mode decision: whether the character ends the field or is stored.
    always_comb begin
        space_cur   = i_state.space_left;
        dropped_cur = i_state.dropped_any;
        if (i_state.mode == MODE_START) begin
            space_cur   = i_capacity;
            dropped_cur = 1'b0;
        end
        swallow = (i_state.mode == MODE_START) && !i_item.in_end
                  && i_state.swallow_lf && (i_item.in_char == ChLf);

        do_end  = 1'b0;
        do_put  = 1'b0;
        term    = TERM_END;
        mode_nx = i_state.mode;

        if (swallow) begin
            mode_nx = MODE_START;
        end else if (i_item.in_end) begin
            do_end = 1'b1;
        end else begin
            unique case (i_state.mode)
                MODE_START: begin
                    if (i_item.in_char == ChQuote) begin
                        mode_nx = MODE_QUOTED;
                    end else begin
                        mode_nx = MODE_PLAIN;
                        do_end  = (cls != TERM_OTHER);
                        do_put  = (cls == TERM_OTHER);
                        term    = cls;
                    end
                end
                MODE_PLAIN: begin
                    do_end = (cls != TERM_OTHER);
                    do_put = (cls == TERM_OTHER);
                    term   = cls;
                end
                MODE_QUOTED: begin
                    if (i_item.in_char == ChQuote) begin
                        mode_nx = MODE_CLOSED;
                    end else begin
                        do_put = 1'b1;
                    end
                end
                MODE_CLOSED: begin
                    if (i_item.in_char == ChQuote) begin
                        mode_nx = MODE_QUOTED;
                        do_put  = 1'b1;
                    end else begin
                        do_end = 1'b1;
                        term   = cls;
                    end
                end
            endcase
        end
    end

    assign fits = (space_cur > len_ext);

    // Result and state update.
    always_comb begin
        o_result.out_kind      = KIND_NONE;
        o_result.out_char      = '0;
        o_result.terminator    = TERM_SEP;
        o_result.end_of_record = 1'b0;
        o_result.truncated     = 1'b0;

        o_state.mode        = mode_nx;
        o_state.space_left  = space_cur;
        o_state.swallow_lf  = 1'b0;
        o_state.dropped_any = dropped_cur;

        if (do_end) begin
            o_result.out_kind      = KIND_END;
            o_result.terminator    = term;
            o_result.end_of_record = (term != TERM_SEP);
            o_result.truncated     = dropped_cur;
            o_state.mode           = MODE_START;
            o_state.space_left     = i_capacity;
            o_state.swallow_lf     = (term == TERM_CR);
            o_state.dropped_any    = 1'b0;
        end else if (do_put) begin
            if (fits) begin
                o_result.out_kind  = KIND_CHAR;
                o_result.out_char  = i_item.in_char;
                o_state.space_left = space_cur - len_ext;
            end else begin
                o_state.dropped_any = 1'b1;
            end
        end
    end

endmodule

FILE: sv/csv_field_splitter_core.sv
// ----------------------------------------------------------------------------
// csv_field_splitter_core
// Splits a stream of decoded characters into delimited, optionally quoted
// fields, one result per input character.
// ----------------------------------------------------------------------------
// Each input transaction is one character and yields exactly one output
// transaction. The block sustains one character per cycle while the sink
// accepts results: the parser step is a small mode update, 16-bit terminator
// compares and a capacity compare and subtract, and the result waits for the
// sink in an output register while the next character waits in the input
// register. Configuration (separator and field capacity) is written through
// a plain write port; the user must write it only while the block is idle,
// which the block does not enforce; a new capacity applies from the next field.
module csv_field_splitter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    csvfs_in_if.sink    i_in,
    csvfs_out_if.source o_out
);
    import csvfs_pkg::*;

    logic [CharW-1:0] r_separator;
    logic [CharW-1:0] r_capacity;
    t_state           r_state;
    t_state           n_state;
    t_item            r_item;
    logic             r_item_valid;
    t_result          r_result;
    t_result          n_result;
    logic             r_out_valid;
    logic             advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator <= SeparatorReset;
            r_capacity  <= CapacityReset;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SEPARATOR: r_separator <= i_cfg_data;
                CFG_CAPACITY:  r_capacity  <= i_cfg_data;
            endcase
        end
    end

    // Pipeline flow: a held character moves on when the result slot is free.
    assign advance    = r_item_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_item_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_item_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.in_char <= i_in.in_char;
            r_item.in_len  <= i_in.in_len;
            r_item.in_end  <= i_in.in_end;
        end
    end

    // Parser step.
    csvfs_step u_step (
        .i_item      (r_item),
        .i_state     (r_state),
        .i_separator (r_separator),
        .i_capacity  (r_capacity),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // Parser state, updated once per parsed character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode        <= MODE_START;
            r_state.space_left  <= CapacityReset;
            r_state.swallow_lf  <= 1'b0;
            r_state.dropped_any <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_kind      = r_result.out_kind;
    assign o_out.out_char      = r_result.out_char;
    assign o_out.terminator    = r_result.terminator;
    assign o_out.end_of_record = r_result.end_of_record;
    assign o_out.truncated     = r_result.truncated;

endmodule
